>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GTGP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define GTGP_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define GTGP_ASSERT(lbl, prop, msg)
`define GTGP_ASSERT_NR(lbl, prop, msg)
`endif
`endif

>>> rtl/gtgp_pkg.sv
// ---------------------------------------------------------------------------
// gtgp_pkg
// shared widths, command and status types of the thread grid partitioner
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gtgp_pkg;

    localparam int DIM_W = 31;
    localparam int THR_W = 11;
    localparam int BLK_W = 32;
    localparam int MUL_W = 43;
    localparam int P_W   = 21;
    localparam int R_W   = 6;
    localparam int CNT_W = 6;
    localparam int IN_W  = 104;
    localparam int OUT_W = 136;

    localparam logic [THR_W-1:0] MAX_THREADS = 11'd1024;
    localparam logic [8:0]       K_MIN_BLK   = 9'd385;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OUT_SINGLE,
        OP_PROD,
        OP_OTHER_INC,
        OP_TN_NTHR,
        OP_TM_NTHR,
        OP_DEC,
        OP_INC,
        OP_R_CLR,
        OP_R_INC,
        OP_REF_SET,
        OP_REF_DEC,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        M_NONE,
        M_P_OTHER,
        M_TMTN,
        M_R1SQ,
        M_BMTM,
        M_BNTN,
        M_BKTK
    } msel_t;

    typedef enum logic [3:0] {
        D_USED,
        D_NTHR,
        D_REF_M,
        D_REF_N,
        D_BM,
        D_BN,
        D_BK,
        D_TM2,
        D_TN2,
        D_TK2
    } dsel_t;

    typedef struct packed {
        op_t   op;
        msel_t msel;
        dsel_t dsel;
        logic  div_start;
    } cmd_t;

    typedef struct packed {
        logic single;
        logic out_free;
        logic div_done;
        logic ksa;
        logic k_room;
        logic mgt;
        logic mlt;
        logic tm_one;
        logic tn_one;
        logic tm_gt1;
        logic tn_gt1;
        logic side_m;
        logic ref_more;
    } status_t;

endpackage

>>> rtl/gtgp_div.sv
// ---------------------------------------------------------------------------
// gtgp_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtgp_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [gtgp_pkg::BLK_W-1:0]   dividend,
    input  logic [gtgp_pkg::BLK_W-1:0]   divisor,
    output logic                         done,
    output logic [gtgp_pkg::BLK_W-1:0]   quotient,
    output logic [gtgp_pkg::BLK_W-1:0]   remainder
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [gtgp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [gtgp_pkg::BLK_W-1:0]   q_reg, q_next;
    logic [gtgp_pkg::BLK_W-1:0]   r_reg, r_next;
    logic [gtgp_pkg::BLK_W-1:0]   d_reg, d_next;
    logic [gtgp_pkg::BLK_W:0]     trial;
    logic [gtgp_pkg::BLK_W:0]     diff;
    logic                         fits;

    assign trial = {r_reg, q_reg[gtgp_pkg::BLK_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = gtgp_pkg::CNT_W'(gtgp_pkg::BLK_W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end else if (busy_reg) begin
            q_next   = {q_reg[gtgp_pkg::BLK_W-2:0], fits};
            r_next   = fits ? diff[gtgp_pkg::BLK_W-1:0] : trial[gtgp_pkg::BLK_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == gtgp_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> rtl/gtgp_datapath.sv
// ---------------------------------------------------------------------------
// gtgp_datapath
// working registers, shared multiplier and divider, output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtgp_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [gtgp_pkg::IN_W-1:0]    s_tdata,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  gtgp_pkg::cmd_t               cmd,
    output gtgp_pkg::status_t            st,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gtgp_pkg::OUT_W-1:0]   m_tdata
);

    logic [gtgp_pkg::DIM_W-1:0] m_reg, n_reg, k_reg;
    logic [gtgp_pkg::THR_W-1:0] total_reg, tm_reg, tn_reg, tk_reg, nthr_reg, other_reg;
    logic [gtgp_pkg::P_W-1:0]   p_reg;
    logic [gtgp_pkg::R_W-1:0]   r_reg;
    logic                       side_m_reg;
    logic                       ksa_reg;
    logic [gtgp_pkg::BLK_W-1:0] bm_reg, bn_reg, bk_reg;
    logic [gtgp_pkg::THR_W-1:0] otm_reg, otn_reg, otk_reg;
    logic [gtgp_pkg::BLK_W-1:0] obm_reg, obn_reg, obk_reg;
    logic                       out_valid_reg;

    logic [gtgp_pkg::DIM_W-1:0] in_m, in_n, in_k;
    logic [gtgp_pkg::THR_W-1:0] in_total, total_sat, tm_init, tn_init;
    logic [gtgp_pkg::BLK_W-1:0] m_sum63;
    logic [gtgp_pkg::BLK_W-1:0] n_sum47;
    logic [24:0]                n_prod;

    logic [gtgp_pkg::BLK_W-1:0] dvd, dvs, div_quo, div_rem;
    logic                       div_done;

    logic [gtgp_pkg::BLK_W-1:0] mul_a;
    logic [gtgp_pkg::THR_W-1:0] mul_b;
    logic [gtgp_pkg::DIM_W-1:0] mul_tgt;
    logic [gtgp_pkg::MUL_W-1:0] mul_res;
    logic [gtgp_pkg::R_W:0]     r_p1;

    logic [20:0]                kmin;
    logic [gtgp_pkg::THR_W-1:0] used;
    logic [14:0]                used10, tot9;
    logic [gtgp_pkg::BLK_W-1:0] m_sum15, bm_sum, bk_sum;
    logic [27:0]                capm;
    logic [gtgp_pkg::DIM_W-1:0] capn;
    logic [gtgp_pkg::R_W-1:0]   rm, rn;

    assign in_m     = s_tdata[30:0];
    assign in_n     = s_tdata[61:31];
    assign in_k     = s_tdata[92:62];
    assign in_total = s_tdata[103:93];

    assign total_sat = (in_total > gtgp_pkg::MAX_THREADS) ? gtgp_pkg::MAX_THREADS : in_total;
    assign m_sum63   = {1'b0, in_m} + 32'd63;
    assign tm_init   = ({6'd0, m_sum63[31:6]} > 32'(total_sat)) ? total_sat
                                                                : m_sum63[16:6];

    // ceil(n/48) as ((n+47)/16)/3, reciprocal of 3 exact below 8192
    assign n_sum47 = {1'b0, in_n} + 32'd47;
    assign n_prod  = 25'(n_sum47[16:4]) * 25'd2731;
    assign tn_init = ((n_sum47[31:17] != '0) || (n_prod[24:13] > 12'(total_sat)))
                   ? total_sat : n_prod[23:13];

    // divider operands
    always_comb begin
        case (cmd.dsel)
            gtgp_pkg::D_USED: begin
                dvd = 32'(total_reg);
                dvs = 32'(other_reg);
            end
            gtgp_pkg::D_NTHR: begin
                dvd = 32'(total_reg);
                dvs = 32'(tk_reg);
            end
            gtgp_pkg::D_REF_M: begin
                dvd = 32'(nthr_reg);
                dvs = 32'(tm_reg);
            end
            gtgp_pkg::D_REF_N: begin
                dvd = 32'(nthr_reg);
                dvs = 32'(tn_reg);
            end
            gtgp_pkg::D_BM: begin
                dvd = {1'b0, m_reg} + 32'(tm_reg) - 32'd1;
                dvs = 32'(tm_reg);
            end
            gtgp_pkg::D_BN: begin
                dvd = {1'b0, n_reg} + 32'(tn_reg) - 32'd1;
                dvs = 32'(tn_reg);
            end
            gtgp_pkg::D_BK: begin
                dvd = {1'b0, k_reg} + 32'(tk_reg) - 32'd1;
                dvs = 32'(tk_reg);
            end
            gtgp_pkg::D_TM2: begin
                dvd = {1'b0, m_reg} + bm_reg - 32'd1;
                dvs = bm_reg;
            end
            gtgp_pkg::D_TN2: begin
                dvd = {1'b0, n_reg} + bn_reg - 32'd1;
                dvs = bn_reg;
            end
            gtgp_pkg::D_TK2: begin
                dvd = {1'b0, k_reg} + bk_reg - 32'd1;
                dvs = bk_reg;
            end
            default: begin
                dvd = '0;
                dvs = 32'd1;
            end
        endcase
    end

    gtgp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dvd),
        .divisor   (dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // shared multiplier and compare
    assign r_p1 = {1'b0, r_reg} + 7'd1;

    always_comb begin
        case (cmd.msel)
            gtgp_pkg::M_P_OTHER: begin
                mul_a   = 32'(p_reg);
                mul_b   = other_reg;
                mul_tgt = 31'(total_reg);
            end
            gtgp_pkg::M_TMTN: begin
                mul_a   = 32'(tm_reg);
                mul_b   = tn_reg;
                mul_tgt = 31'(nthr_reg);
            end
            gtgp_pkg::M_R1SQ: begin
                mul_a   = 32'(r_p1);
                mul_b   = 11'(r_p1);
                mul_tgt = 31'(nthr_reg);
            end
            gtgp_pkg::M_BMTM: begin
                mul_a   = bm_reg;
                mul_b   = tm_reg;
                mul_tgt = m_reg;
            end
            gtgp_pkg::M_BNTN: begin
                mul_a   = bn_reg;
                mul_b   = tn_reg;
                mul_tgt = n_reg;
            end
            gtgp_pkg::M_BKTK: begin
                mul_a   = bk_reg;
                mul_b   = tk_reg;
                mul_tgt = k_reg;
            end
            default: begin
                mul_a   = '0;
                mul_b   = '0;
                mul_tgt = '0;
            end
        endcase
    end

    assign mul_res = 43'(mul_a) * 43'(mul_b);

    assign kmin   = 21'({1'b0, other_reg} + 12'd1) * 21'(gtgp_pkg::K_MIN_BLK);
    assign used   = total_reg - div_rem[10:0];
    assign used10 = 15'(used) * 15'd10;
    assign tot9   = 15'(total_reg) * 15'd9;

    assign m_sum15 = {1'b0, m_reg} + 32'd15;
    assign capm    = (m_sum15[31:4] == '0) ? 28'd1 : m_sum15[31:4];
    assign capn    = (n_reg == '0) ? 31'd1 : n_reg;
    assign rm      = (28'(r_reg) > capm) ? capm[5:0] : r_reg;
    assign rn      = (31'(r_reg) > capn) ? capn[5:0] : r_reg;

    assign bm_sum   = div_quo + 32'd15;
    assign bk_sum   = div_quo + 32'd3;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksa_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ksa_reg <= cfg_wr_data;
            end
            if (cmd.op == gtgp_pkg::OP_OUT || cmd.op == gtgp_pkg::OP_OUT_SINGLE) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gtgp_pkg::OP_LOAD: begin
                m_reg     <= in_m;
                n_reg     <= in_n;
                k_reg     <= in_k;
                total_reg <= total_sat;
                tm_reg    <= tm_init;
                tn_reg    <= tn_init;
                tk_reg    <= 11'd1;
                other_reg <= 11'd1;
            end
            gtgp_pkg::OP_PROD: begin
                p_reg <= mul_res[20:0];
            end
            gtgp_pkg::OP_OTHER_INC: begin
                other_reg <= other_reg + 11'd1;
            end
            gtgp_pkg::OP_TN_NTHR: begin
                tn_reg <= nthr_reg;
            end
            gtgp_pkg::OP_TM_NTHR: begin
                tm_reg <= nthr_reg;
            end
            gtgp_pkg::OP_DEC: begin
                if (tm_reg > tn_reg) begin
                    tm_reg <= tm_reg - 11'd1;
                end else begin
                    tn_reg <= tn_reg - 11'd1;
                end
            end
            gtgp_pkg::OP_INC: begin
                if (tm_reg < tn_reg) begin
                    tm_reg <= tm_reg + 11'd1;
                end else begin
                    tn_reg <= tn_reg + 11'd1;
                end
            end
            gtgp_pkg::OP_R_CLR: begin
                r_reg      <= '0;
                side_m_reg <= (tm_reg <= tn_reg);
            end
            gtgp_pkg::OP_R_INC: begin
                r_reg <= r_reg + 6'd1;
            end
            gtgp_pkg::OP_REF_SET: begin
                if (side_m_reg) begin
                    tm_reg <= 11'(rm);
                end else begin
                    tn_reg <= 11'(rn);
                end
            end
            gtgp_pkg::OP_REF_DEC: begin
                if (side_m_reg) begin
                    tm_reg <= tm_reg - 11'd1;
                end else begin
                    tn_reg <= tn_reg - 11'd1;
                end
            end
            gtgp_pkg::OP_OUT: begin
                otm_reg <= tm_reg;
                otn_reg <= tn_reg;
                otk_reg <= tk_reg;
                obm_reg <= bm_reg;
                obn_reg <= bn_reg;
                obk_reg <= bk_reg;
            end
            gtgp_pkg::OP_OUT_SINGLE: begin
                otm_reg <= 11'd1;
                otn_reg <= 11'd1;
                otk_reg <= 11'd1;
                obm_reg <= {1'b0, m_reg};
                obn_reg <= {1'b0, n_reg};
                obk_reg <= {1'b0, k_reg};
            end
            default: begin
            end
        endcase

        if (div_done) begin
            case (cmd.dsel)
                gtgp_pkg::D_USED: begin
                    if (used10 > tot9) begin
                        tk_reg <= other_reg;
                    end
                end
                gtgp_pkg::D_NTHR:  nthr_reg <= div_quo[10:0];
                gtgp_pkg::D_REF_M: tn_reg <= div_quo[10:0];
                gtgp_pkg::D_REF_N: tm_reg <= div_quo[10:0];
                gtgp_pkg::D_BM:    bm_reg <= {bm_sum[31:4], 4'd0};
                gtgp_pkg::D_BN:    bn_reg <= div_quo;
                gtgp_pkg::D_BK:    bk_reg <= {bk_sum[31:2], 2'd0};
                gtgp_pkg::D_TM2:   tm_reg <= div_quo[10:0];
                gtgp_pkg::D_TN2:   tn_reg <= div_quo[10:0];
                gtgp_pkg::D_TK2:   tk_reg <= div_quo[10:0];
                default: begin
                end
            endcase
        end
    end

    assign st.single   = (total_reg <= 11'd1);
    assign st.out_free = !out_valid_reg || m_tready;
    assign st.div_done = div_done;
    assign st.ksa      = ksa_reg;
    assign st.k_room   = (other_reg < total_reg) && (31'(kmin) <= k_reg);
    assign st.mgt      = mul_res > 43'(mul_tgt);
    assign st.mlt      = mul_res < 43'(mul_tgt);
    assign st.tm_one   = (tm_reg == 11'd1);
    assign st.tn_one   = (tn_reg == 11'd1);
    assign st.tm_gt1   = (tm_reg > 11'd1);
    assign st.tn_gt1   = (tn_reg > 11'd1);
    assign st.side_m   = side_m_reg;
    assign st.ref_more = side_m_reg ? (tm_reg > 11'd1) : (tn_reg > 11'd1);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, obk_reg, obn_reg, obm_reg, otk_reg, otn_reg, otm_reg};

endmodule

>>> rtl/gtgp_ctrl.sv
// ---------------------------------------------------------------------------
// gtgp_ctrl
// sequencer for the partition steps, drives the datapath by commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gtgp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  gtgp_pkg::status_t   st,
    output gtgp_pkg::cmd_t      cmd
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_CHK     = 17'h00002,
        S_DSTART  = 17'h00004,
        S_DWAIT   = 17'h00008,
        S_PROD    = 17'h00010,
        S_KCHK    = 17'h00020,
        S_FIX1    = 17'h00040,
        S_FIX2    = 17'h00080,
        S_DEC     = 17'h00100,
        S_INC     = 17'h00200,
        S_REFCHK  = 17'h00400,
        S_SQRT    = 17'h00800,
        S_REFLOOP = 17'h01000,
        S_TRIMM   = 17'h02000,
        S_TRIMN   = 17'h04000,
        S_TRIMK   = 17'h08000,
        S_OUT     = 17'h10000
    } state_t;

    state_t          state_reg, state_next;
    gtgp_pkg::dsel_t dsel_reg, dsel_next;

    always_comb begin
        state_next    = state_reg;
        dsel_next     = dsel_reg;
        cmd.op        = gtgp_pkg::OP_NONE;
        cmd.msel      = gtgp_pkg::M_NONE;
        cmd.dsel      = dsel_reg;
        cmd.div_start = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = gtgp_pkg::OP_LOAD;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (st.single) begin
                    if (st.out_free) begin
                        cmd.op     = gtgp_pkg::OP_OUT_SINGLE;
                        state_next = S_IDLE;
                    end
                end else begin
                    state_next = S_PROD;
                end
            end
            S_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT: begin
                if (st.div_done) begin
                    case (dsel_reg)
                        gtgp_pkg::D_USED:  state_next = S_KCHK;
                        gtgp_pkg::D_NTHR:  state_next = S_FIX1;
                        gtgp_pkg::D_REF_M,
                        gtgp_pkg::D_REF_N: state_next = S_REFLOOP;
                        gtgp_pkg::D_BM: begin
                            dsel_next  = gtgp_pkg::D_BN;
                            state_next = S_DSTART;
                        end
                        gtgp_pkg::D_BN: begin
                            dsel_next  = gtgp_pkg::D_BK;
                            state_next = S_DSTART;
                        end
                        gtgp_pkg::D_BK:    state_next = S_TRIMM;
                        gtgp_pkg::D_TM2:   state_next = S_TRIMN;
                        gtgp_pkg::D_TN2:   state_next = S_TRIMK;
                        gtgp_pkg::D_TK2:   state_next = S_OUT;
                        default:           state_next = S_IDLE;
                    endcase
                end
            end
            S_PROD: begin
                cmd.msel   = gtgp_pkg::M_TMTN;
                cmd.op     = gtgp_pkg::OP_PROD;
                state_next = S_KCHK;
            end
            S_KCHK: begin
                cmd.msel   = gtgp_pkg::M_P_OTHER;
                state_next = S_DSTART;
                if (st.ksa && st.k_room && st.mlt) begin
                    cmd.op    = gtgp_pkg::OP_OTHER_INC;
                    dsel_next = gtgp_pkg::D_USED;
                end else begin
                    dsel_next = gtgp_pkg::D_NTHR;
                end
            end
            S_FIX1: begin
                if (st.tm_one) begin
                    cmd.op = gtgp_pkg::OP_TN_NTHR;
                end
                state_next = S_FIX2;
            end
            S_FIX2: begin
                if (st.tn_one) begin
                    cmd.op = gtgp_pkg::OP_TM_NTHR;
                end
                state_next = S_DEC;
            end
            S_DEC: begin
                cmd.msel = gtgp_pkg::M_TMTN;
                if (st.mgt) begin
                    cmd.op = gtgp_pkg::OP_DEC;
                end else begin
                    state_next = S_INC;
                end
            end
            S_INC: begin
                cmd.msel = gtgp_pkg::M_TMTN;
                if (st.mlt) begin
                    cmd.op = gtgp_pkg::OP_INC;
                end else begin
                    state_next = S_REFCHK;
                end
            end
            S_REFCHK: begin
                cmd.msel = gtgp_pkg::M_TMTN;
                if (st.mgt && st.tm_gt1 && st.tn_gt1) begin
                    cmd.op     = gtgp_pkg::OP_R_CLR;
                    state_next = S_SQRT;
                end else begin
                    dsel_next  = gtgp_pkg::D_BM;
                    state_next = S_DSTART;
                end
            end
            S_SQRT: begin
                cmd.msel = gtgp_pkg::M_R1SQ;
                if (!st.mgt) begin
                    cmd.op = gtgp_pkg::OP_R_INC;
                end else begin
                    cmd.op     = gtgp_pkg::OP_REF_SET;
                    dsel_next  = st.side_m ? gtgp_pkg::D_REF_M : gtgp_pkg::D_REF_N;
                    state_next = S_DSTART;
                end
            end
            S_REFLOOP: begin
                cmd.msel   = gtgp_pkg::M_TMTN;
                state_next = S_DSTART;
                if (st.ref_more && (st.mgt || st.mlt)) begin
                    cmd.op = gtgp_pkg::OP_REF_DEC;
                end else begin
                    dsel_next = gtgp_pkg::D_BM;
                end
            end
            S_TRIMM: begin
                cmd.msel = gtgp_pkg::M_BMTM;
                if (st.mgt) begin
                    dsel_next  = gtgp_pkg::D_TM2;
                    state_next = S_DSTART;
                end else begin
                    state_next = S_TRIMN;
                end
            end
            S_TRIMN: begin
                cmd.msel = gtgp_pkg::M_BNTN;
                if (st.mgt) begin
                    dsel_next  = gtgp_pkg::D_TN2;
                    state_next = S_DSTART;
                end else begin
                    state_next = S_TRIMK;
                end
            end
            S_TRIMK: begin
                cmd.msel = gtgp_pkg::M_BKTK;
                if (st.mgt) begin
                    dsel_next  = gtgp_pkg::D_TK2;
                    state_next = S_DSTART;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (st.out_free) begin
                    cmd.op     = gtgp_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dsel_reg  <= gtgp_pkg::D_USED;
        end else begin
            state_reg <= state_next;
            dsel_reg  <= dsel_next;
        end
    end

endmodule

>>> rtl/gemm_thread_grid_partition_core.sv
// ---------------------------------------------------------------------------
// gemm_thread_grid_partition_core
// splits a gemm of size m x n x k over a thread count into a 3d thread grid
// ---------------------------------------------------------------------------
// One transaction in, one transaction out. A single thread is written to the
// output register from the check state once that register is free. Otherwise
// the time is set by the shared restoring divider, which runs 4 + S + R + T
// divisions, and by the one-step-per-cycle balancing loops, where S is the
// number of k split candidates tried (up to the thread count), R the divisor
// search steps (up to 32) and T the thread counts trimmed (up to 3). The worst
// case is a tiny m x n with very deep k and 1024 threads. A finished result
// waits in the output register while the next transaction is taken.
// k_split_allowed may be written only while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gemm_thread_grid_partition_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // rows_m[30:0], cols_n[61:31], depth_k[92:62], thread_total[103:93]
    input  logic [gtgp_pkg::IN_W-1:0]    s_tdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // threads_m[10:0], threads_n[21:11], threads_k[32:22],
    // block_m[64:33], block_n[96:65], block_k[128:97]
    output logic [gtgp_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data
);

    gtgp_pkg::cmd_t    cmd;
    gtgp_pkg::status_t st;
    logic              out_load;

    assign out_load = (cmd.op == gtgp_pkg::OP_OUT) || (cmd.op == gtgp_pkg::OP_OUT_SINGLE);

    gtgp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    gtgp_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .st          (st),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    `GTGP_ASSERT(a_busy_after_accept, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
    `GTGP_ASSERT(a_no_overwrite, out_load |-> st.out_free, "result overwritten")
    `GTGP_ASSERT_NR(a_load_on_accept, (cmd.op == gtgp_pkg::OP_LOAD) |-> (s_tvalid && s_tready), "load without transaction")

endmodule
